/* sv/srdp_pkg.sv */
// ----------------------------------------------------------------------------
// srdp_pkg
// Shared types and constants of the stepper ramp delay profile.
// ----------------------------------------------------------------------------
package srdp_pkg;

  // field widths
  localparam int DLY_W     = 16;
  localparam int CNT_W_DEF = 16;
  localparam int NUM_W     = 32;
  localparam int Q_W       = 16;
  localparam int X_W       = 12;
  localparam int E_W       = 13;
  localparam int SQ_W      = 2 * X_W;
  localparam int POLY_W    = 38;

  // s-curve scale is 2**SC_SHIFT
  localparam int SC_SHIFT  = 12;
  localparam int SC_THREE  = 3 * (1 << SC_SHIFT);

  // pipeline depths
  localparam int PREP_STAGES  = 2;
  localparam int DIV_STAGES   = Q_W;
  localparam int SHAPE_STAGES = 4;
  localparam int NUM_STAGES   = PREP_STAGES + DIV_STAGES + SHAPE_STAGES;

  // configuration register map
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam logic [2:0] REG_CRUISE_C = 3'd0;
  localparam logic [2:0] REG_CRUISE_Z = 3'd1;
  localparam logic [2:0] REG_START_C  = 3'd2;
  localparam logic [2:0] REG_START_Z  = 3'd3;
  localparam logic [2:0] REG_ACCEL_C  = 3'd4;
  localparam logic [2:0] REG_RAMP_Z   = 3'd5;
  localparam logic [2:0] REG_DECEL_C  = 3'd6;

  localparam logic [DLY_W-1:0] RST_CRUISE_C = 16'd300;
  localparam logic [DLY_W-1:0] RST_CRUISE_Z = 16'd50;
  localparam logic [DLY_W-1:0] RST_START_C  = 16'd3000;
  localparam logic [DLY_W-1:0] RST_START_Z  = 16'd1000;
  localparam logic [DLY_W-1:0] RST_ACCEL_C  = 16'd500;
  localparam logic [DLY_W-1:0] RST_RAMP_Z   = 16'd180;
  localparam logic [DLY_W-1:0] RST_DECEL_C  = 16'd1000;

  typedef struct packed {
    logic [DLY_W-1:0] cruise_c;
    logic [DLY_W-1:0] cruise_z;
    logic [DLY_W-1:0] start_c;
    logic [DLY_W-1:0] start_z;
    logic [DLY_W-1:0] accel_c;
    logic [DLY_W-1:0] ramp_z;
    logic [DLY_W-1:0] decel_c;
  } cfg_t;

  // per-transaction control carried alongside the ramps
  typedef struct packed {
    logic             is_c;
    logic             dec_en;
    logic             act_a;
    logic             act_d;
    logic [DLY_W-1:0] start;
    logic [DLY_W-1:0] cruise;
    logic [DLY_W-1:0] delta;
  } side_t;

endpackage

/* sv/srdp_prep.sv */
// ----------------------------------------------------------------------------
// srdp_prep
// Ramp length capping, progress and numerator forming, two register stages.
// ----------------------------------------------------------------------------
module srdp_prep import srdp_pkg::*; #(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input  logic                   clk_i,
  input  logic [PREP_STAGES-1:0] en_i,
  input  cfg_t                   cfg_i,
  input  logic                   direction_i,
  input  logic [COUNT_WIDTH-1:0] step_number_i,
  input  logic [COUNT_WIDTH-1:0] planned_total_i,
  output logic [NUM_W-1:0]       num_a_o,
  output logic [NUM_W-1:0]       num_d_o,
  output logic [Q_W-1:0]         len_a_o,
  output logic [Q_W-1:0]         len_d_o,
  output side_t                  side_o
);

  localparam int W = (COUNT_WIDTH > DLY_W) ? COUNT_WIDTH : DLY_W;

  logic [W-1:0]     step_w, total_w, half_w, rem_w;
  logic [DLY_W-1:0] acc_raw, dec_raw, acc_cap, dec_cap, acc_len, dec_len;
  logic [DLY_W-1:0] acc_p, dec_p, start, cruise;
  logic             dec_en;

  logic [Q_W-1:0]   acc_len_q, dec_len_q, acc_p_q, dec_p_q;
  side_t            side_q;

  // lengths and progress
  always_comb begin
    step_w  = W'(step_number_i);
    total_w = W'(planned_total_i);
    half_w  = total_w >> 1;
    dec_en  = (total_w != '0);
    start   = direction_i ? cfg_i.start_c  : cfg_i.start_z;
    cruise  = direction_i ? cfg_i.cruise_c : cfg_i.cruise_z;
    acc_raw = direction_i ? cfg_i.accel_c  : cfg_i.ramp_z;
    dec_raw = direction_i ? cfg_i.decel_c  : cfg_i.ramp_z;
    acc_cap = (dec_en && (half_w < W'(acc_raw))) ? half_w[DLY_W-1:0] : acc_raw;
    dec_cap = (dec_en && (half_w < W'(dec_raw))) ? half_w[DLY_W-1:0] : dec_raw;
    acc_len = (acc_cap == '0) ? DLY_W'(1) : acc_cap;
    dec_len = (dec_cap == '0) ? DLY_W'(1) : dec_cap;
    acc_p   = (step_w > W'(acc_len)) ? acc_len : step_w[DLY_W-1:0];
    rem_w   = (total_w > step_w) ? (total_w - step_w) : '0;
    dec_p   = (rem_w > W'(dec_len)) ? dec_len : rem_w[DLY_W-1:0];
  end

  // first stage
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      acc_len_q     <= acc_len;
      dec_len_q     <= dec_len;
      acc_p_q       <= acc_p;
      dec_p_q       <= dec_p;
      side_q.is_c   <= direction_i;
      side_q.dec_en <= dec_en;
      side_q.act_a  <= (acc_p < acc_len) && (start > cruise);
      side_q.act_d  <= (dec_p < dec_len) && (start > cruise);
      side_q.start  <= start;
      side_q.cruise <= cruise;
      side_q.delta  <= start - cruise;
    end
  end

  // second stage: dividend is delta*p (linear) or p*scale (s-curve)
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num_a_o <= side_q.is_c ? (NUM_W'(acc_p_q) << SC_SHIFT) : (side_q.delta * acc_p_q);
      num_d_o <= side_q.is_c ? (NUM_W'(dec_p_q) << SC_SHIFT) : (side_q.delta * dec_p_q);
      len_a_o <= acc_len_q;
      len_d_o <= dec_len_q;
      side_o  <= side_q;
    end
  end

endmodule

/* sv/srdp_div.sv */
// ----------------------------------------------------------------------------
// srdp_div
// Two-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module srdp_div import srdp_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [NUM_W-1:0]      num_a_i,
  input  logic [NUM_W-1:0]      num_d_i,
  input  logic [Q_W-1:0]        len_a_i,
  input  logic [Q_W-1:0]        len_d_i,
  input  side_t                 side_i,
  output logic [Q_W-1:0]        q_a_o,
  output logic [Q_W-1:0]        q_d_o,
  output side_t                 side_o
);

  localparam int LO_W = NUM_W - Q_W;

  // stage registers, lane 0 is acceleration, lane 1 deceleration
  logic [Q_W-1:0]  rem_q [DIV_STAGES][2];
  logic [LO_W-1:0] lo_q  [DIV_STAGES][2];
  logic [Q_W-1:0]  qt_q  [DIV_STAGES][2];
  logic [Q_W-1:0]  len_q [DIV_STAGES][2];
  side_t           side_q[DIV_STAGES];

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [Q_W:0] div_step(input logic [Q_W-1:0] rem,
                                            input logic           nbit,
                                            input logic [Q_W-1:0] len);
    logic [Q_W:0] t;
    logic [Q_W:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, len};
    if (t >= {1'b0, len}) begin
      div_step = {1'b1, diff[Q_W-1:0]};
    end else begin
      div_step = {1'b0, t[Q_W-1:0]};
    end
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [Q_W-1:0]  rem_in [2];
    logic [LO_W-1:0] lo_in  [2];
    logic [Q_W-1:0]  qt_in  [2];
    logic [Q_W-1:0]  len_in [2];
    side_t           side_in;
    logic [Q_W:0]    res    [2];

    always_comb begin
      if (s == 0) begin
        rem_in[0] = num_a_i[NUM_W-1:LO_W];
        rem_in[1] = num_d_i[NUM_W-1:LO_W];
        lo_in[0]  = num_a_i[LO_W-1:0];
        lo_in[1]  = num_d_i[LO_W-1:0];
        qt_in[0]  = '0;
        qt_in[1]  = '0;
        len_in[0] = len_a_i;
        len_in[1] = len_d_i;
        side_in   = side_i;
      end else begin
        rem_in[0] = rem_q[s-1][0];
        rem_in[1] = rem_q[s-1][1];
        lo_in[0]  = lo_q[s-1][0];
        lo_in[1]  = lo_q[s-1][1];
        qt_in[0]  = qt_q[s-1][0];
        qt_in[1]  = qt_q[s-1][1];
        len_in[0] = len_q[s-1][0];
        len_in[1] = len_q[s-1][1];
        side_in   = side_q[s-1];
      end
      res[0] = div_step(rem_in[0], lo_in[0][LO_W-1], len_in[0]);
      res[1] = div_step(rem_in[1], lo_in[1][LO_W-1], len_in[1]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[s][l] <= res[l][Q_W-1:0];
          lo_q[s][l]  <= lo_in[l] << 1;
          qt_q[s][l]  <= {qt_in[l][Q_W-2:0], res[l][Q_W]};
          len_q[s][l] <= len_in[l];
        end
        side_q[s] <= side_in;
      end
    end
  end

  assign q_a_o  = qt_q[DIV_STAGES-1][0];
  assign q_d_o  = qt_q[DIV_STAGES-1][1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

/* sv/srdp_shape.sv */
// ----------------------------------------------------------------------------
// srdp_shape
// S-curve polynomial, ramp delays and final max against cruise.
// ----------------------------------------------------------------------------
module srdp_shape import srdp_pkg::*; (
  input  logic                    clk_i,
  input  logic [SHAPE_STAGES-1:0] en_i,
  input  logic [Q_W-1:0]          q_a_i,
  input  logic [Q_W-1:0]          q_d_i,
  input  side_t                   side_i,
  output logic [DLY_W-1:0]        delay_o
);

  logic [X_W-1:0]   x_q   [2];
  logic [SQ_W-1:0]  sq_q  [2];
  logic [Q_W-1:0]   qa_q  [2];
  logic [Q_W-1:0]   qb_q  [2];
  logic [E_W-1:0]   e_q   [2];
  logic [DLY_W-1:0] r_q   [2];
  side_t            sa_q, sb_q, sc_q;

  logic [POLY_W-1:0]    poly [2];
  logic [DLY_W+E_W-1:0] prod [2];
  logic [DLY_W-1:0]     amt  [2];
  logic                 act  [2];
  logic [DLY_W-1:0]     best;

  // square of the normalized progress
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]  <= q_a_i[X_W-1:0];
      x_q[1]  <= q_d_i[X_W-1:0];
      sq_q[0] <= q_a_i[X_W-1:0] * q_a_i[X_W-1:0];
      sq_q[1] <= q_d_i[X_W-1:0] * q_d_i[X_W-1:0];
      qa_q[0] <= q_a_i;
      qa_q[1] <= q_d_i;
      sa_q    <= side_i;
    end
  end

  // smoothstep x*x*(3*scale - 2*x) over scale squared
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      poly[l] = POLY_W'(sq_q[l]) * POLY_W'(SC_THREE - 2 * int'(x_q[l]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int l = 0; l < 2; l++) begin
        e_q[l]  <= poly[l][2*SC_SHIFT +: E_W];
        qb_q[l] <= qa_q[l];
      end
      sb_q <= sa_q;
    end
  end

  // ramp delay per lane
  always_comb begin
    act[0] = sb_q.act_a;
    act[1] = sb_q.act_d;
    for (int l = 0; l < 2; l++) begin
      prod[l] = sb_q.delta * e_q[l];
      amt[l]  = sb_q.is_c ? prod[l][SC_SHIFT +: DLY_W] : qb_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int l = 0; l < 2; l++) begin
        r_q[l] <= act[l] ? (sb_q.start - amt[l]) : sb_q.cruise;
      end
      sc_q <= sb_q;
    end
  end

  // larger of both ramps (deceleration only with a planned total), never below cruise
  always_comb begin
    best = r_q[0];
    if (sc_q.dec_en && (r_q[1] > best)) begin
      best = r_q[1];
    end
    if (sc_q.cruise > best) begin
      best = sc_q.cruise;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      delay_o <= best;
    end
  end

endmodule

/* sv/stepper_ramp_delay_profile.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_delay_profile
// Per-step delay for an accelerating and decelerating stepper move.
// ----------------------------------------------------------------------------
// The block takes one step request per clock while the output is not stalled
// and computes its delay in a pipeline: ramp length capping and dividend
// forming, then the restoring divider (one quotient bit per stage, both
// ramps in parallel lanes), then the s-curve multiplies and the final max.
// Stalls on the output only hold back stages that are occupied, so bubbles
// inside the pipeline are still filled while a result waits. The user must
// write the registers over the APB port only while no transaction is in
// flight; the block itself does not enforce this.
module stepper_ramp_delay_profile import srdp_pkg::*; #(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   direction_i,
  input  logic [COUNT_WIDTH-1:0] step_number_i,
  input  logic [COUNT_WIDTH-1:0] planned_total_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DLY_W-1:0]       delay_us_o
);

  cfg_t                  cfg_q;
  logic [2:0]            reg_idx;
  logic [NUM_STAGES-1:0] v_q, v_d, en;

  logic [NUM_W-1:0] num_a, num_d;
  logic [Q_W-1:0]   len_a, len_d, q_a, q_d;
  side_t            side_p, side_v;

  // register file
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_c <= RST_CRUISE_C;
      cfg_q.cruise_z <= RST_CRUISE_Z;
      cfg_q.start_c  <= RST_START_C;
      cfg_q.start_z  <= RST_START_Z;
      cfg_q.accel_c  <= RST_ACCEL_C;
      cfg_q.ramp_z   <= RST_RAMP_Z;
      cfg_q.decel_c  <= RST_DECEL_C;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CRUISE_C: cfg_q.cruise_c <= pwdata[DLY_W-1:0];
        REG_CRUISE_Z: cfg_q.cruise_z <= pwdata[DLY_W-1:0];
        REG_START_C:  cfg_q.start_c  <= pwdata[DLY_W-1:0];
        REG_START_Z:  cfg_q.start_z  <= pwdata[DLY_W-1:0];
        REG_ACCEL_C:  cfg_q.accel_c  <= pwdata[DLY_W-1:0];
        REG_RAMP_Z:   cfg_q.ramp_z   <= pwdata[DLY_W-1:0];
        REG_DECEL_C:  cfg_q.decel_c  <= pwdata[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_CRUISE_C: prdata = DATA_W'(cfg_q.cruise_c);
      REG_CRUISE_Z: prdata = DATA_W'(cfg_q.cruise_z);
      REG_START_C:  prdata = DATA_W'(cfg_q.start_c);
      REG_START_Z:  prdata = DATA_W'(cfg_q.start_z);
      REG_ACCEL_C:  prdata = DATA_W'(cfg_q.accel_c);
      REG_RAMP_Z:   prdata = DATA_W'(cfg_q.ramp_z);
      REG_DECEL_C:  prdata = DATA_W'(cfg_q.decel_c);
      default:      prdata = '0;
    endcase
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (!en[k]) begin
        v_d[k] = v_q[k];
      end else if (k == 0) begin
        v_d[k] = in_valid_i;
      end else begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  srdp_prep #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_prep (
    .clk_i,
    .en_i            (en[PREP_STAGES-1:0]),
    .cfg_i           (cfg_q),
    .direction_i,
    .step_number_i,
    .planned_total_i,
    .num_a_o         (num_a),
    .num_d_o         (num_d),
    .len_a_o         (len_a),
    .len_d_o         (len_d),
    .side_o          (side_p)
  );

  srdp_div u_div (
    .clk_i,
    .en_i    (en[PREP_STAGES +: DIV_STAGES]),
    .num_a_i (num_a),
    .num_d_i (num_d),
    .len_a_i (len_a),
    .len_d_i (len_d),
    .side_i  (side_p),
    .q_a_o   (q_a),
    .q_d_o   (q_d),
    .side_o  (side_v)
  );

  srdp_shape u_shape (
    .clk_i,
    .en_i    (en[PREP_STAGES+DIV_STAGES +: SHAPE_STAGES]),
    .q_a_i   (q_a),
    .q_d_i   (q_d),
    .side_i  (side_v),
    .delay_o (delay_us_o)
  );

endmodule

/* sv/srdp_checker.sv */
// ----------------------------------------------------------------------------
// srdp_checker
// Port-level checks of the stepper ramp delay profile, bound to the top.
// ----------------------------------------------------------------------------
module srdp_checker import srdp_pkg::*; #(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   direction_i,
  input logic [COUNT_WIDTH-1:0] step_number_i,
  input logic [COUNT_WIDTH-1:0] planned_total_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [DLY_W-1:0]       delay_us_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(delay_us_o)))
    else $error("stalled result changed");

  // a waiting request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(direction_i) &&
      $stable(step_number_i) && $stable(planned_total_i)))
    else $error("waiting request changed");

  // an empty output stage never blocks intake
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("intake blocked with empty output");

  // a result taken frees the whole pipeline for one new transaction
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> in_ready_o)
    else $error("intake blocked while result is taken");

  // no result shows up right after reset without intake
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind stepper_ramp_delay_profile srdp_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_srdp_checker (.*);

/* verif/stepper_ramp_delay_profile_test.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_delay_profile_test
// Drives step requests and register settings into the ramp delay block and
// checks every returned delay against an in-bench profile calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stepper_ramp_delay_profile_test import srdp_pkg::*;;

  localparam int CW        = 16;
  localparam int LATENCY   = NUM_STAGES;
  localparam int CYCLE_CAP = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              direction_i = 1'b0;
  logic [CW-1:0]     step_number_i = '0;
  logic [CW-1:0]     planned_total_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DLY_W-1:0]  delay_us_o;

  // shadow copy of the register file
  logic [DLY_W-1:0] sh_cruise_c, sh_cruise_z, sh_start_c, sh_start_z;
  logic [DLY_W-1:0] sh_accel_c, sh_ramp_z, sh_decel_c;

  logic [DLY_W-1:0] pending_delays[$];
  int unsigned      errors = 0;
  int unsigned      cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      stall_mode = 0;

  stepper_ramp_delay_profile #(.COUNT_WIDTH(CW)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .direction_i(direction_i), .step_number_i(step_number_i),
    .planned_total_i(planned_total_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .delay_us_o(delay_us_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("stepper_ramp_delay_profile_test NOT OK");
      $finish;
    end
  end

  // one ramp point, linear or s-curve
  function automatic logic [31:0] ramp_point(logic scurve, logic [63:0] p, logic [63:0] len,
                                             logic [31:0] start, logic [31:0] cruise);
    logic [63:0] delta, x, e;
    if (len == 64'd0 || p >= len || start <= cruise) return cruise;
    delta = 64'(start - cruise);
    if (!scurve) return start - 32'((delta * p) / len);
    x = (p * 64'd4096) / len;
    e = ((64'd3 * x * x * 64'd4096) - (64'd2 * x * x * x)) / (64'd4096 * 64'd4096);
    return start - 32'((delta * e) / 64'd4096);
  endfunction

  function automatic logic [DLY_W-1:0] profile_delay(logic dir, logic [CW-1:0] step,
                                                     logic [CW-1:0] total);
    logic [31:0] cruise, start, d, d2;
    logic [63:0] acc_len, dec_len, acc_p, dec_p, half;
    cruise  = 32'(dir ? sh_cruise_c : sh_cruise_z);
    start   = 32'(dir ? sh_start_c : sh_start_z);
    acc_len = 64'(dir ? sh_accel_c : sh_ramp_z);
    dec_len = 64'(dir ? sh_decel_c : sh_ramp_z);
    if (total != '0) begin
      half = 64'(total >> 1);
      if (half < acc_len) acc_len = half;
      if (half < dec_len) dec_len = half;
    end
    if (acc_len == 64'd0) acc_len = 64'd1;
    if (dec_len == 64'd0) dec_len = 64'd1;
    acc_p = (64'(step) > acc_len) ? acc_len : 64'(step);
    d = ramp_point(dir, acc_p, acc_len, start, cruise);
    if (total != '0) begin
      dec_p = (total > step) ? 64'(total - step) : 64'd0;
      if (dec_p > dec_len) dec_p = dec_len;
      d2 = ramp_point(dir, dec_p, dec_len, start, cruise);
      if (d2 > d) d = d2;
    end
    if (d < cruise) d = cruise;
    return d[DLY_W-1:0];
  endfunction

  // receiver stall pattern, changed now and then
  always @(negedge clk_i) begin
    if (($urandom % 200) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom % 4) != 0;
      2: out_ready_i <= ($urandom % 2) != 0;
      default: out_ready_i <= ($urandom % 8) == 0;
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    logic [DLY_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_delays.size() == 0) begin
        $error("delay_us: result with nothing expected, actual %0d", delay_us_o);
        errors++;
      end else begin
        want = pending_delays.pop_front();
        if (want !== delay_us_o) begin
          $error("delay_us: expected %0d actual %0d", want, delay_us_o);
          errors++;
        end
      end
    end
  end

  // valid stays high across a burst and drops only for a gap or a drain
  task automatic send_step(logic dir, logic [CW-1:0] step, logic [CW-1:0] total);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    direction_i     <= dir;
    step_number_i   <= step;
    planned_total_i <= total;
    do @(posedge clk_i); while (!in_ready_o);
    pending_delays.push_back(profile_delay(dir, step, total));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_delays.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // psel stays high between back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [DLY_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= {16'(~val), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    case (idx)
      REG_CRUISE_C: sh_cruise_c = val;
      REG_CRUISE_Z: sh_cruise_z = val;
      REG_START_C:  sh_start_c = val;
      REG_START_Z:  sh_start_z = val;
      REG_ACCEL_C:  sh_accel_c = val;
      REG_RAMP_Z:   sh_ramp_z = val;
      default:      sh_decel_c = val;
    endcase
  endtask

  task automatic load_profile(logic [DLY_W-1:0] cc, logic [DLY_W-1:0] cz,
                              logic [DLY_W-1:0] sc, logic [DLY_W-1:0] sz,
                              logic [DLY_W-1:0] ac, logic [DLY_W-1:0] rz,
                              logic [DLY_W-1:0] dc);
    drain_results();
    write_reg(REG_CRUISE_C, cc); write_reg(REG_CRUISE_Z, cz);
    write_reg(REG_START_C, sc);  write_reg(REG_START_Z, sz);
    write_reg(REG_ACCEL_C, ac);  write_reg(REG_RAMP_Z, rz);
    write_reg(REG_DECEL_C, dc);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // extremes of the fields and the named corner cases, first with the reset settings, then with loaded profiles
  task automatic test_directed();
    send_step(1'b1, 16'd0, 16'd0);
    send_step(1'b0, 16'd0, 16'd0);
    send_step(1'b1, 16'hFFFF, 16'hFFFF);
    send_step(1'b0, 16'hFFFF, 16'hFFFF);
    send_step(1'b1, 16'd250, 16'd3000);
    send_step(1'b0, 16'd90, 16'd3000);
    send_step(1'b1, 16'd2500, 16'd3000);
    send_step(1'b0, 16'd2950, 16'd3000);
    send_step(1'b1, 16'd10, 16'd5);
    send_step(1'b0, 16'd5, 16'd5);
    send_step(1'b1, 16'd0, 16'd1);
    send_step(1'b0, 16'd1, 16'd3);
    send_step(1'b1, 16'd600, 16'd0);
    send_step(1'b0, 16'd100, 16'd0);
    // start at or below cruise
    load_profile(16'd500, 16'd500, 16'd500, 16'd100, 16'd0, 16'd0, 16'd0);
    send_step(1'b1, 16'd0, 16'd10);
    send_step(1'b0, 16'd3, 16'd10);
    send_step(1'b1, 16'd0, 16'd0);
    // full-range delays and ramps
    load_profile(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_step(1'b1, 16'd1, 16'hFFFF);
    send_step(1'b0, 16'd1, 16'hFFFF);
    send_step(1'b1, 16'h7FFF, 16'd0);
    send_step(1'b0, 16'hFFFE, 16'd0);
    send_step(1'b1, 16'hFFFE, 16'hFFFF);
  endtask

  task automatic random_moves(int unsigned count);
    logic [CW-1:0] total, step;
    logic          dir;
    int unsigned   n;
    n = 0;
    while (n < count) begin
      dir = 1'($urandom_range(0, 1));
      case ($urandom % 4)
        0: total = CW'($urandom);
        1: total = CW'($urandom_range(0, 20));
        default: total = CW'($urandom_range(0, 4000));
      endcase
      // a run of consecutive steps through the move, or scattered noise
      if ($urandom % 4 != 0) begin
        step = (total > 8) ? CW'($urandom_range(0, total)) : '0;
        repeat ($urandom_range(4, 30)) begin
          send_step(dir, step, total); step++; n++;
        end
      end else begin
        send_step(dir, CW'($urandom), total); n++;
      end
    end
  endtask

  task automatic test_reset_profile();
    random_moves(300);
  endtask

  task automatic test_random_profiles();
    repeat (5) begin
      load_profile(DLY_W'($urandom_range(0, 2000)), DLY_W'($urandom_range(0, 2000)),
                   DLY_W'($urandom), DLY_W'($urandom_range(0, 5000)),
                   DLY_W'($urandom_range(0, 3000)), DLY_W'($urandom_range(0, 3000)),
                   DLY_W'($urandom));
      random_moves(260);
    end
  endtask

  task automatic test_narrow_ramps();
    load_profile(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
    random_moves(120);
    load_profile(16'd1, 16'd7, 16'd40000, 16'd9, 16'd3, 16'd2, 16'd5);
    random_moves(120);
  endtask

  initial begin
    sh_cruise_c = RST_CRUISE_C; sh_cruise_z = RST_CRUISE_Z;
    sh_start_c  = RST_START_C;  sh_start_z  = RST_START_Z;
    sh_accel_c  = RST_ACCEL_C;  sh_ramp_z   = RST_RAMP_Z;
    sh_decel_c  = RST_DECEL_C;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    load_profile(RST_CRUISE_C, RST_CRUISE_Z, RST_START_C, RST_START_Z,
                 RST_ACCEL_C, RST_RAMP_Z, RST_DECEL_C);
    test_reset_profile();
    test_random_profiles();
    test_narrow_ramps();
    drain_results();
    if (errors == 0) begin
      $display("stepper_ramp_delay_profile_test OK");
    end else begin
      $display("stepper_ramp_delay_profile_test NOT OK");
    end
    $finish;
  end

endmodule
